FILE: sv/sha256sh_pkg.sv
`timescale 1ns / 1ps
// sha256sh_pkg: shared types, constants and round functions for the SHA-256 stream hasher.
// No dependencies.
package sha256sh_pkg;

	typedef enum logic [2:0] {
		ST_ABSORB,
		ST_PAD,
		ST_ROUND,
		ST_FINAL,
		ST_OUT
	} state_t;

	localparam int unsigned BlockBytes = 64;
	localparam int unsigned LenBytes   = 61;  // byte count saturates at 2^61-1

	localparam logic [7:0] PAD_MARK = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;  // first byte of the bit length field

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
		ror = (v >> s) | (v << (32 - s));
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] ch(input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z);
		ch = (x & y) ^ (~x & z);
	endfunction

	function automatic logic [31:0] maj(input logic [31:0] x, input logic [31:0] y,
		input logic [31:0] z);
		maj = (x & y) ^ (x & z) ^ (y & z);
	endfunction

endpackage

FILE: sv/sha256sh_msg_if.sv
`timescale 1ns / 1ps
// sha256sh_msg_if: message byte channel (valid/ready plus byte payload).
// No dependencies.
interface sha256sh_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_message;

	modport source (output valid, data_byte, byte_present, end_of_message, input ready);
	modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

FILE: sv/sha256sh_dig_if.sv
`timescale 1ns / 1ps
// sha256sh_dig_if: digest part channel (valid/ready plus 64-bit part payload).
// No dependencies.
interface sha256sh_dig_if;
	logic        valid;
	logic        ready;
	logic [63:0] digest_part;
	logic [1:0]  part_number;
	logic        last_part;
	logic        length_error;

	modport source (output valid, digest_part, part_number, last_part, length_error,
		input ready);
	modport sink   (input valid, digest_part, part_number, last_part, length_error,
		output ready);
endinterface

FILE: sv/sha256_stream_hasher_unit.sv
`timescale 1ns / 1ps
// sha256_stream_hasher_unit: SHA-256 over a byte stream, one shared round unit.
// Depends on sha256sh_pkg, sha256sh_msg_if, sha256sh_dig_if.
//
//  channel | dir | payload                                             | handshake
//  --------+-----+-----------------------------------------------------+----------
//  msg     | in  | data_byte[7:0], byte_present, end_of_message        | valid/ready
//  digest  | out | digest_part[63:0], part_number[1:0], last_part,     | valid/ready
//          |     | length_error                                        |
//
// Bytes are taken while absorbing; the 64th byte of a block starts the rounds
// and then the chaining add, with msg.ready low meanwhile.
// End of message: padding bytes are pushed up to the block end, then the
// compression (a second block when the mark lands at byte 56 or later),
// then four digest transfers. digest.ready low simply holds the current part.
// After reset (arst_n low) the chaining words hold the standard initial values.
module sha256_stream_hasher_unit
	import sha256sh_pkg::*;
(
	input logic clk,
	input logic arst_n,
	sha256sh_msg_if.sink   msg,
	sha256sh_dig_if.source digest
);

	state_t state_q, state_d;

	// 512-bit block register: byte shift line while filling, message schedule window
	// (w[t]..w[t+15], w[t] on top) while compressing.
	logic [8*BlockBytes-1:0] blk_q;
	logic [31:0]             h_q [8];
	logic [31:0]             v_q [8];
	logic [5:0]              fill_q;
	logic [5:0]              rnd_q;
	logic [LenBytes-1:0]     len_q;
	logic                    ovf_q;
	logic                    fin_q;
	logic                    mark_q;
	logic                    lenok_q;
	logic [1:0]              part_q;

	logic       push;
	logic [7:0] push_byte;
	logic       take_byte;
	logic       start_cmp;

	logic [63:0] len_bits;
	logic [63:0] len_shift;
	logic [7:0]  pad_byte;

	logic [31:0] w0, w1, w9, w14;
	logic [31:0] w_new, t1, t2;

	assign len_bits  = {len_q, 3'b000};
	assign len_shift = len_bits << {fill_q[2:0], 3'b000};

	always_comb begin
		if (!mark_q) begin
			pad_byte = PAD_MARK;
		end else if (lenok_q && fill_q >= LEN_POS) begin
			pad_byte = len_shift[63:56];
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign w0  = blk_q[511:480];
	assign w1  = blk_q[479:448];
	assign w9  = blk_q[223:192];
	assign w14 = blk_q[63:32];

	assign w_new = ssig1(w14) + w9 + ssig0(w1) + w0;
	assign t1 = v_q[7] + bsig1(v_q[4]) + ch(v_q[4], v_q[5], v_q[6]) + ROUND_K[rnd_q] + w0;
	assign t2 = bsig0(v_q[0]) + maj(v_q[0], v_q[1], v_q[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ABSORB;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		push         = 1'b0;
		push_byte    = msg.data_byte;
		take_byte    = 1'b0;
		start_cmp    = 1'b0;
		msg.ready    = 1'b0;
		digest.valid = 1'b0;
		unique case (state_q)
			ST_ABSORB: begin
				msg.ready = 1'b1;
				if (msg.valid) begin
					if (msg.byte_present) begin
						push      = 1'b1;
						take_byte = 1'b1;
					end
					if (msg.byte_present && fill_q == 6'd63) begin
						start_cmp = 1'b1;
						state_d   = ST_ROUND;
					end else if (msg.end_of_message) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				push      = 1'b1;
				push_byte = pad_byte;
				if (fill_q == 6'd63) begin
					start_cmp = 1'b1;
					state_d   = ST_ROUND;
				end
			end
			ST_ROUND: begin
				if (rnd_q == 6'd63) begin
					state_d = ST_FINAL;
				end
			end
			ST_FINAL: begin
				if (!fin_q) begin
					state_d = ST_ABSORB;
				end else if (lenok_q) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_PAD;
				end
			end
			ST_OUT: begin
				digest.valid = 1'b1;
				if (digest.ready && part_q == 2'd3) begin
					state_d = ST_ABSORB;
				end
			end
			default: begin
				state_d = ST_ABSORB;
			end
		endcase
	end

	// control and chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			rnd_q   <= '0;
			len_q   <= '0;
			ovf_q   <= 1'b0;
			fin_q   <= 1'b0;
			mark_q  <= 1'b0;
			lenok_q <= 1'b0;
			part_q  <= '0;
			for (int i = 0; i < 8; i++) begin
				h_q[i] <= INIT_H[i];
			end
		end else begin
			if (push) begin
				fill_q <= fill_q + 6'd1;
			end
			if (take_byte) begin
				if (&len_q) begin
					ovf_q <= 1'b1;
				end else begin
					len_q <= len_q + {{(LenBytes-1){1'b0}}, 1'b1};
				end
			end
			if (state_q == ST_ABSORB && msg.valid && msg.end_of_message) begin
				fin_q <= 1'b1;
			end
			if (state_q == ST_PAD && !mark_q) begin
				mark_q <= 1'b1;
				if (fill_q < LEN_POS) begin
					lenok_q <= 1'b1;
				end
			end
			// extra block done: the length goes into the next one
			if (state_q == ST_FINAL && fin_q && mark_q) begin
				lenok_q <= 1'b1;
			end
			if (start_cmp) begin
				rnd_q <= '0;
			end else if (state_q == ST_ROUND) begin
				rnd_q <= rnd_q + 6'd1;
			end
			if (state_q == ST_FINAL) begin
				for (int i = 0; i < 8; i++) begin
					h_q[i] <= h_q[i] + v_q[i];
				end
			end
			if (state_q == ST_OUT && digest.ready) begin
				part_q <= part_q + 2'd1;
				if (part_q == 2'd3) begin
					fill_q  <= '0;
					len_q   <= '0;
					ovf_q   <= 1'b0;
					fin_q   <= 1'b0;
					mark_q  <= 1'b0;
					lenok_q <= 1'b0;
					for (int i = 0; i < 8; i++) begin
						h_q[i] <= INIT_H[i];
					end
				end else begin
					// move the next word pair to the top
					for (int i = 0; i < 6; i++) begin
						h_q[i] <= h_q[i+2];
					end
				end
			end
		end
	end

	// block register and working variables
	always_ff @(posedge clk) begin
		if (push) begin
			blk_q <= {blk_q[8*BlockBytes-9:0], push_byte};
		end else if (state_q == ST_ROUND) begin
			blk_q <= {blk_q[8*BlockBytes-33:0], w_new};
		end
		if (start_cmp) begin
			for (int i = 0; i < 8; i++) begin
				v_q[i] <= h_q[i];
			end
		end else if (state_q == ST_ROUND) begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end
	end

	assign digest.digest_part  = {h_q[0], h_q[1]};
	assign digest.part_number  = part_q;
	assign digest.last_part    = (part_q == 2'd3);
	assign digest.length_error = ovf_q;

endmodule

FILE: test/sha256sh_tb_pkg.sv
`timescale 1ns / 1ps
// sha256sh_tb_pkg: SHA-256 digest predictor and digest part scoreboard for tb_top.
// No dependencies on the RTL; imported by tb_top.
package sha256sh_tb_pkg;

	typedef struct packed {
		logic [63:0] digest_part;
		logic [1:0]  part_number;
		logic        last_part;
		logic        length_error;
	} digest_beat_t;

	localparam bit [63:0] LEN_LIMIT = 64'h1fff_ffff_ffff_ffff;

	localparam bit [31:0] RK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam bit [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic bit [31:0] rot_right(input bit [31:0] v, input int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	class digest_scoreboard;
		bit [31:0]    hash_words [8];
		bit [7:0]     blk [64];
		int unsigned  fill;
		bit [63:0]    byte_count;
		bit           too_long;
		digest_beat_t expected_parts [$];
		int unsigned  mismatches;
		int unsigned  parts_seen;
		int unsigned  messages;

		function new();
			restart();
			mismatches = 0;
			parts_seen = 0;
			messages   = 0;
		endfunction

		function void restart();
			hash_words = IV;
			fill       = 0;
			byte_count = '0;
			too_long   = 1'b0;
		endfunction

		function int pending();
			return expected_parts.size();
		endfunction

		function void compress();
			bit [31:0] w [64];
			bit [31:0] v [8];
			bit [31:0] x, y, t1, t2;
			int i;
			for (i = 0; i < 16; i++) begin
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			end
			for (i = 16; i < 64; i++) begin
				x = w[i-15];
				y = w[i-2];
				w[i] = w[i-16] + (rot_right(x, 7) ^ rot_right(x, 18) ^ (x >> 3)) + w[i-7]
					+ (rot_right(y, 17) ^ rot_right(y, 19) ^ (y >> 10));
			end
			v = hash_words;
			for (i = 0; i < 64; i++) begin
				t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
					+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + RK[i] + w[i];
				t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
					+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
				v[7] = v[6];
				v[6] = v[5];
				v[5] = v[4];
				v[4] = v[3] + t1;
				v[3] = v[2];
				v[2] = v[1];
				v[1] = v[0];
				v[0] = t1 + t2;
			end
			for (i = 0; i < 8; i++) begin
				hash_words[i] += v[i];
			end
		endfunction

		// one accepted input transfer; queues four digest parts when the message ends
		function void absorb_item(bit [7:0] data, bit present, bit eom);
			bit [63:0]    bit_len;
			digest_beat_t part;
			int           i;
			if (present) begin
				if (byte_count >= LEN_LIMIT) begin
					too_long = 1'b1;
				end else begin
					byte_count++;
				end
				blk[fill] = data;
				fill++;
				if (fill == 64) begin
					compress();
					fill = 0;
				end
			end
			if (!eom) return;
			bit_len = byte_count << 3;
			blk[fill] = 8'h80;
			fill++;
			// length field no longer fits: pad out and spend an extra block
			if (fill > 56) begin
				while (fill < 64) begin
					blk[fill] = 8'h00;
					fill++;
				end
				compress();
				fill = 0;
			end
			while (fill < 56) begin
				blk[fill] = 8'h00;
				fill++;
			end
			for (i = 0; i < 8; i++) begin
				blk[63-i] = bit_len[8*i +: 8];
			end
			compress();
			for (i = 0; i < 4; i++) begin
				part.digest_part  = {hash_words[2*i], hash_words[2*i+1]};
				part.part_number  = 2'(i);
				part.last_part    = (i == 3);
				part.length_error = too_long;
				expected_parts.insert(expected_parts.size(), part);
			end
			messages++;
			restart();
		endfunction

		function void flag_error(string what, digest_beat_t want, digest_beat_t got);
			if (mismatches < 10) begin
				$display("ERROR %s: exp data=%h part=%0d last=%b err=%b", what,
					want.digest_part, want.part_number, want.last_part, want.length_error);
				$display("      got data=%h part=%0d last=%b err=%b",
					got.digest_part, got.part_number, got.last_part, got.length_error);
			end
			mismatches++;
		endfunction

		function void check_part(digest_beat_t got);
			digest_beat_t want;
			parts_seen++;
			if (expected_parts.size() == 0) begin
				flag_error("unexpected digest transfer", '0, got);
				return;
			end
			want = expected_parts.pop_front();
			if (got.digest_part !== want.digest_part || got.part_number !== want.part_number
				|| got.last_part !== want.last_part || got.length_error !== want.length_error) begin
				flag_error("digest part mismatch", want, got);
			end
		endfunction
	endclass

endpackage

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: random and directed byte-stream test of sha256_stream_hasher_unit.
// Depends on sha256sh_pkg, the msg/digest interfaces and sha256sh_tb_pkg.
module tb_top;
	import sha256sh_tb_pkg::*;

	localparam int unsigned ITEM_TARGET  = 350;
	localparam int unsigned DRAIN_CYCLES = 300;
	localparam int LEN_EDGES [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

	logic clk;
	logic arst_n;

	sha256sh_msg_if msg_ch ();
	sha256sh_dig_if dig_ch ();

	sha256_stream_hasher_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dig_ch)
	);

	digest_scoreboard sb;
	int unsigned items_sent;
	int unsigned idle_sent;
	int unsigned rx_hold_left;
	int unsigned rx_stall_left;
	bit          steady;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#10000000;
		$display("TIMEOUT: %0d digest parts still outstanding", sb.pending());
		$display("*** FAILED ***");
		$finish;
	end

	// mostly short gaps, now and then a long one; none during steady stretches
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic send_item(input bit [7:0] data, input bit present, input bit eom);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			msg_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_ch.valid          <= 1'b1;
		msg_ch.data_byte      <= data;
		msg_ch.byte_present   <= present;
		msg_ch.end_of_message <= eom;
		@(posedge clk);
		while (msg_ch.ready !== 1'b1) @(posedge clk);
		sb.absorb_item(data, present, eom);
		if (present || eom) begin
			items_sent++;
		end else begin
			idle_sent++;
		end
	endtask

	task automatic send_message(input int len, input bit empty_end);
		int i;
		for (i = 0; i < len; i++) begin
			if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			send_item(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !empty_end);
		end
		if (empty_end || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
	endtask

	// sender goes quiet until every queued digest part has been checked
	task automatic wait_for_digests();
		msg_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// digest receiver: checks each transfer, then picks ready for the next cycle
	initial begin
		digest_beat_t got;
		dig_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (dig_ch.valid === 1'b1 && dig_ch.ready === 1'b1) begin
				got.digest_part  = dig_ch.digest_part;
				got.part_number  = dig_ch.part_number;
				got.last_part    = dig_ch.last_part;
				got.length_error = dig_ch.length_error;
				sb.check_part(got);
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				dig_ch.ready <= 1'b0;
			end else if (rx_stall_left > 0) begin
				rx_stall_left--;
				dig_ch.ready <= 1'b0;
			end else begin
				dig_ch.ready <= 1'b1;
				rx_stall_left = pick_gap();
			end
		end
	end

	initial begin
		int unsigned r;
		sb                    = new();
		items_sent            = 0;
		idle_sent             = 0;
		rx_hold_left          = 0;
		rx_stall_left         = 0;
		steady                = 1'b0;
		arst_n                = 1'b0;
		msg_ch.valid          = 1'b0;
		msg_ch.data_byte      = 8'h00;
		msg_ch.byte_present   = 1'b0;
		msg_ch.end_of_message = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(8'h00, 1'b0, 1'b1);        // empty message
		send_item(8'h61, 1'b1, 1'b0);        // "abc", end on the last byte
		send_item(8'h62, 1'b1, 1'b0);
		send_item(8'h63, 1'b1, 1'b1);
		send_item(8'h5a, 1'b0, 1'b0);        // idle transfer between messages
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'hff, 1'b0, 1'b0);
		send_item(8'hff, 1'b1, 1'b0);
		send_item(8'ha5, 1'b0, 1'b1);        // bytes closed by an empty end marker
		send_item(8'h80, 1'b1, 1'b1);
		send_item(8'h7f, 1'b1, 1'b1);
		wait_for_digests();

		// digest side stalls for a long time while messages keep coming
		rx_hold_left = 300;
		send_message(5, 1'b0);
		send_message(0, 1'b1);
		send_message(2, 1'b1);

		while (items_sent < ITEM_TARGET) begin
			steady = ($urandom_range(0, 5) == 0);
			r = $urandom_range(0, 99);
			if (r < 50) begin
				send_message($urandom_range(0, 12), $urandom_range(0, 2) == 0);
			end else if (r < 80) begin
				send_message(LEN_EDGES[$urandom_range(0, 9)], 1'($urandom_range(0, 1)));
			end else if (r < 90) begin
				send_message($urandom_range(13, 70), $urandom_range(0, 2) == 0);
			end else begin
				repeat ($urandom_range(1, 8))
					send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)));
			end
		end
		steady = 1'b0;

		wait_for_digests();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Hashed %0d messages from %0d byte/end transfers plus %0d idle transfers,",
			sb.messages, items_sent, idle_sent);
		$display("checked %0d digest parts, %0d mismatches", sb.parts_seen, sb.mismatches);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
